FILE: sv/mwm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mwm_pkg
// Types, request codes and defaults shared by the maze wall map block.
// ----------------------------------------------------------------------------
package mwm_pkg;

  localparam int GRID_SIZE_DEF = 32;

  localparam logic [2:0] REQ_ADD       = 3'd0;
  localparam logic [2:0] REQ_SET       = 3'd1;
  localparam logic [2:0] REQ_MARK      = 3'd2;
  localparam logic [2:0] REQ_READ      = 3'd3;
  localparam logic [2:0] REQ_READ_KNWN = 3'd4;
  localparam logic [2:0] REQ_CLR_ALL   = 3'd5;
  localparam logic [2:0] REQ_CLR_RCH   = 3'd6;

  // wall mask bit positions
  localparam int SIDE_N = 0;
  localparam int SIDE_E = 1;
  localparam int SIDE_S = 2;
  localparam int SIDE_W = 3;

  typedef struct packed {
    logic [2:0] req_type;
    logic [4:0] x_pos;
    logic [4:0] y_pos;
    logic [3:0] wall_mask;
  } req_t;

  typedef struct packed {
    logic [3:0] walls_out;
    logic       cell_reached;
  } rsp_t;

  typedef struct packed {
    logic vld;
    req_t req;
  } stage_t;

endpackage
`default_nettype wire

FILE: sv/mwm_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mwm_req_if / mwm_rsp_if
// Valid/ready channels for map requests and map results.
// ----------------------------------------------------------------------------
interface mwm_req_if;
  logic       valid;
  logic       ready;
  logic [2:0] req_type;
  logic [4:0] x_pos;
  logic [4:0] y_pos;
  logic [3:0] wall_mask;

  modport source (output valid, req_type, x_pos, y_pos, wall_mask, input ready);
  modport sink (input valid, req_type, x_pos, y_pos, wall_mask, output ready);
endinterface

interface mwm_rsp_if;
  logic       valid;
  logic       ready;
  logic [3:0] walls_out;
  logic       cell_reached;

  modport source (output valid, walls_out, cell_reached, input ready);
  modport sink (input valid, walls_out, cell_reached, output ready);
endinterface
`default_nettype wire

FILE: sv/maze_wall_map_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// maze_wall_map_top
// Maze wall and reached-cell map with one request in and one result out.
// ----------------------------------------------------------------------------
//   channel   dir  payload
//   in_ch     in   req_type, x_pos, y_pos, wall_mask
//   out_ch    out  walls_out, cell_reached
//
// One request per cycle while out_ch is not stalled; a result beat is offered once
// its request beat has passed the input register, then map update and result register.
// Map state is flip-flops cleared by rst_n to the start-up maze; no clear pass.
// A stall on out_ch holds the staged request; in_ch keeps taking beats while
// the input register is empty or moving.
// ----------------------------------------------------------------------------
module maze_wall_map_top
  import mwm_pkg::*;
#(
  parameter int GRID_SIZE = GRID_SIZE_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  mwm_req_if.sink   in_ch,
  mwm_rsp_if.source out_ch
);

  stage_t stg;
  rsp_t   rsp;
  logic   free;
  logic   adv;

  assign adv = stg.vld && free;

  mwm_in_stage u_in (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .adv   (adv),
    .stg   (stg)
  );

  mwm_map #(
    .GRID_SIZE (GRID_SIZE)
  ) u_map (
    .clk   (clk),
    .rst_n (rst_n),
    .stg   (stg),
    .adv   (adv),
    .rsp   (rsp)
  );

  mwm_out_stage u_out (
    .clk    (clk),
    .rst_n  (rst_n),
    .load   (adv),
    .rsp    (rsp),
    .free   (free),
    .out_ch (out_ch)
  );

endmodule
`default_nettype wire

FILE: sv/mwm_in_stage.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mwm_in_stage
// Request input register; holds one beat until the map stage takes it.
// ----------------------------------------------------------------------------
module mwm_in_stage
  import mwm_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  mwm_req_if.sink     in_ch,
  input  wire logic   adv,
  output stage_t      stg
);

  logic vld_r, vld_nxt;
  req_t req_r;

  assign in_ch.ready = !vld_r || adv;
  assign vld_nxt     = in_ch.valid || (vld_r && !adv);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      req_r <= '{req_type:  in_ch.req_type,
                 x_pos:     in_ch.x_pos,
                 y_pos:     in_ch.y_pos,
                 wall_mask: in_ch.wall_mask};
    end
  end

  assign stg.vld = vld_r;
  assign stg.req = req_r;

endmodule
`default_nettype wire

FILE: sv/mwm_map.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mwm_map
// Wall and reached bitmaps; decodes the staged request, updates the map and
// forms the result in the same cycle.
// ----------------------------------------------------------------------------
module mwm_map
  import mwm_pkg::*;
#(
  parameter int GRID_SIZE = GRID_SIZE_DEF
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire stage_t stg,
  input  wire logic   adv,
  output rsp_t        rsp
);

  localparam int IW = $clog2(GRID_SIZE);

  logic [GRID_SIZE-2:0][GRID_SIZE-1:0] hw_r, hw_nxt;
  logic [GRID_SIZE-2:0][GRID_SIZE-1:0] vw_r, vw_nxt;
  logic [GRID_SIZE-1:0][GRID_SIZE-1:0] rb_r, rb_nxt;

  req_t          r;
  logic [IW-1:0] xi, yi, xm, ym, xp, yp;
  logic          ing, n_ok, e_ok, s_ok, w_ok;
  logic [3:0]    wall, nb_rch;
  logic          r_c, is_add;

  assign r  = stg.req;
  assign xi = IW'(r.x_pos);
  assign yi = IW'(r.y_pos);
  assign xm = xi - 1'b1;
  assign ym = yi - 1'b1;
  assign xp = xi + 1'b1;
  assign yp = yi + 1'b1;

  assign ing  = (32'(r.x_pos) < GRID_SIZE) && (32'(r.y_pos) < GRID_SIZE);
  assign n_ok = ing && (32'(r.y_pos) + 32'd1 < GRID_SIZE);
  assign e_ok = ing && (32'(r.x_pos) + 32'd1 < GRID_SIZE);
  assign s_ok = ing && (r.y_pos != 5'd0);
  assign w_ok = ing && (r.x_pos != 5'd0);

  // boundary and outside sides read as walls
  assign wall[SIDE_N] = n_ok ? hw_r[yi][xi] : 1'b1;
  assign wall[SIDE_E] = e_ok ? vw_r[xi][yi] : 1'b1;
  assign wall[SIDE_S] = s_ok ? hw_r[ym][xi] : 1'b1;
  assign wall[SIDE_W] = w_ok ? vw_r[xm][yi] : 1'b1;

  assign r_c            = ing && rb_r[yi][xi];
  assign nb_rch[SIDE_N] = n_ok && rb_r[yp][xi];
  assign nb_rch[SIDE_E] = e_ok && rb_r[yi][xp];
  assign nb_rch[SIDE_S] = s_ok && rb_r[ym][xi];
  assign nb_rch[SIDE_W] = w_ok && rb_r[yi][xm];

  assign is_add = (r.req_type == REQ_ADD);

  always_comb begin
    hw_nxt = hw_r;
    vw_nxt = vw_r;
    rb_nxt = rb_r;
    if (adv) begin
      unique case (r.req_type) inside
        REQ_ADD, REQ_SET: begin
          if (n_ok) hw_nxt[yi][xi] = r.wall_mask[SIDE_N] | (is_add & hw_r[yi][xi]);
          if (e_ok) vw_nxt[xi][yi] = r.wall_mask[SIDE_E] | (is_add & vw_r[xi][yi]);
          if (s_ok) hw_nxt[ym][xi] = r.wall_mask[SIDE_S] | (is_add & hw_r[ym][xi]);
          if (w_ok) vw_nxt[xm][yi] = r.wall_mask[SIDE_W] | (is_add & vw_r[xm][yi]);
        end
        REQ_MARK: begin
          if (ing) rb_nxt[yi][xi] = 1'b1;
        end
        REQ_CLR_ALL: begin
          hw_nxt = '0;
          vw_nxt = '0;
          rb_nxt = '0;
        end
        REQ_CLR_RCH: begin
          rb_nxt = '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    rsp.walls_out    = 4'd0;
    rsp.cell_reached = r_c;
    unique case (r.req_type) inside
      REQ_MARK:                 rsp.cell_reached = ing;
      REQ_READ:                 rsp.walls_out = wall;
      REQ_READ_KNWN:            rsp.walls_out = wall | ~({4{r_c}} | nb_rch);
      REQ_CLR_ALL, REQ_CLR_RCH: rsp.cell_reached = 1'b0;
      default: begin
      end
    endcase
  end

  // start-up maze: only the east wall of cell (0,0)
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hw_r <= '0;
      vw_r <= {{((GRID_SIZE-1)*GRID_SIZE-1){1'b0}}, 1'b1};
      rb_r <= '0;
    end else begin
      hw_r <= hw_nxt;
      vw_r <= vw_nxt;
      rb_r <= rb_nxt;
    end
  end

  a_clr_all: assert property (@(posedge clk) disable iff (!rst_n)
    adv && (r.req_type == REQ_CLR_ALL) |=> (hw_r == '0) && (vw_r == '0) && (rb_r == '0))
    else $error("map not empty after clear all");

  a_mark: assert property (@(posedge clk) disable iff (!rst_n)
    adv && (r.req_type == REQ_MARK) && ing |=> rb_r[$past(yi)][$past(xi)])
    else $error("reached bit not set after mark");

  a_outside: assert property (@(posedge clk) disable iff (!rst_n)
    adv && !ing && (r.req_type == REQ_READ) |-> (rsp.walls_out == 4'hF) && !rsp.cell_reached)
    else $error("outside cell read not all walls");

endmodule
`default_nettype wire

FILE: sv/mwm_out_stage.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mwm_out_stage
// Result register driving the result channel.
// ----------------------------------------------------------------------------
module mwm_out_stage
  import mwm_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic load,
  input  wire rsp_t rsp,
  output logic      free,
  mwm_rsp_if.source out_ch
);

  logic vld_r, vld_nxt;
  rsp_t rsp_r;

  assign free    = !vld_r || out_ch.ready;
  assign vld_nxt = load || (vld_r && !out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rsp_r <= rsp;
    end
  end

  assign out_ch.valid        = vld_r;
  assign out_ch.walls_out    = rsp_r.walls_out;
  assign out_ch.cell_reached = rsp_r.cell_reached;

endmodule
`default_nettype wire

FILE: verif/maze_wall_map_top_tb.sv
`default_nettype none
// ----------------------------------------------------------------------------
// maze_wall_map_top_tb
// Self-checking bench for the maze wall map. A directed table covers reset
// contents, boundary sides, known-wall reads, clears and the unused request
// code. A random phase follows, biased toward neighboring cells so that
// shared walls and reached neighbors matter. Every accepted request beat runs
// through a bench-side map model, and every result beat is compared with the
// oldest predicted result. Both handshake sides idle at random.
// ----------------------------------------------------------------------------
module maze_wall_map_top_tb;
  import mwm_pkg::*;

  localparam int GRID = GRID_SIZE_DEF;
  localparam int LAST = GRID - 1;
  localparam logic [2:0] REQ_NONE = 3'd7;
  localparam int N_RANDOM = 2000;
  localparam int N_DIR = 24;

  typedef struct packed {
    req_t req;
    logic chk;
    rsp_t rsp;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n;

  mwm_req_if in_ch();
  mwm_rsp_if out_ch();

  maze_wall_map_top #(.GRID_SIZE(GRID)) uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // map model: hwall[y] bit x between (x,y),(x,y+1); vwall[x] bit y between (x,y),(x+1,y)
  logic [GRID-1:0] hwall [GRID-1];
  logic [GRID-1:0] vwall [GRID-1];
  logic [GRID-1:0] rmap  [GRID];

  rsp_t pending_rsp [$];
  int   mismatch_cnt = 0;
  int   rsp_cnt = 0;
  logic tx_idle_on = 1'b1;
  logic rx_idle_on = 1'b1;
  logic rx_hold_done = 1'b0;

  dir_row_t dir_tab [N_DIR] = '{
    '{'{REQ_READ,      5'd0,  5'd0,  4'b0000}, 1'b1, '{4'b1110, 1'b0}},
    '{'{REQ_READ,      5'd31, 5'd31, 4'b0000}, 1'b1, '{4'b0011, 1'b0}},
    '{'{REQ_READ_KNWN, 5'd5,  5'd5,  4'b0000}, 1'b1, '{4'b1111, 1'b0}},
    '{'{REQ_ADD,       5'd31, 5'd31, 4'b1111}, 1'b1, '{4'b0000, 1'b0}},
    '{'{REQ_READ,      5'd31, 5'd31, 4'b0000}, 1'b1, '{4'b1111, 1'b0}},
    '{'{REQ_SET,       5'd31, 5'd31, 4'b0000}, 1'b1, '{4'b0000, 1'b0}},
    '{'{REQ_READ,      5'd31, 5'd31, 4'b1111}, 1'b1, '{4'b0011, 1'b0}},
    '{'{REQ_SET,       5'd0,  5'd31, 4'b0101}, 1'b0, '{4'b0000, 1'b0}},
    '{'{REQ_READ,      5'd0,  5'd31, 4'b0000}, 1'b0, '{4'b0000, 1'b0}},
    '{'{REQ_ADD,       5'd15, 5'd16, 4'b1010}, 1'b0, '{4'b0000, 1'b0}},
    '{'{REQ_READ,      5'd15, 5'd16, 4'b0000}, 1'b0, '{4'b0000, 1'b0}},
    '{'{REQ_MARK,      5'd15, 5'd16, 4'b0000}, 1'b1, '{4'b0000, 1'b1}},
    '{'{REQ_READ_KNWN, 5'd15, 5'd16, 4'b0000}, 1'b0, '{4'b0000, 1'b0}},
    '{'{REQ_READ_KNWN, 5'd15, 5'd17, 4'b0000}, 1'b0, '{4'b0000, 1'b0}},
    '{'{REQ_MARK,      5'd0,  5'd0,  4'b1111}, 1'b1, '{4'b0000, 1'b1}},
    '{'{REQ_MARK,      5'd31, 5'd0,  4'b0000}, 1'b1, '{4'b0000, 1'b1}},
    '{'{REQ_READ,      5'd31, 5'd0,  4'b0000}, 1'b0, '{4'b0000, 1'b0}},
    '{'{REQ_READ_KNWN, 5'd30, 5'd0,  4'b0000}, 1'b0, '{4'b0000, 1'b0}},
    '{'{REQ_NONE,      5'd0,  5'd0,  4'b1111}, 1'b1, '{4'b0000, 1'b1}},
    '{'{REQ_CLR_RCH,   5'd0,  5'd0,  4'b0000}, 1'b1, '{4'b0000, 1'b0}},
    '{'{REQ_READ_KNWN, 5'd0,  5'd0,  4'b0000}, 1'b1, '{4'b1111, 1'b0}},
    '{'{REQ_CLR_ALL,   5'd3,  5'd3,  4'b1111}, 1'b1, '{4'b0000, 1'b0}},
    '{'{REQ_READ,      5'd0,  5'd0,  4'b0000}, 1'b1, '{4'b1100, 1'b0}},
    '{'{REQ_READ_KNWN, 5'd31, 5'd31, 4'b0000}, 1'b0, '{4'b0000, 1'b0}}
  };

  task automatic map_clear(input logic walls_too);
    for (int i = 0; i < GRID; i++) begin
      rmap[i] = '0;
      if (walls_too && i < LAST) begin
        hwall[i] = '0;
        vwall[i] = '0;
      end
    end
  endtask

  function automatic logic wall_at(int x, int y, int d);
    case (d)
      SIDE_N:  return (y == LAST) ? 1'b1 : hwall[y][x];
      SIDE_E:  return (x == LAST) ? 1'b1 : vwall[x][y];
      SIDE_S:  return (y == 0) ? 1'b1 : hwall[y-1][x];
      default: return (x == 0) ? 1'b1 : vwall[x-1][y];
    endcase
  endfunction

  function automatic logic nbr_reached(int x, int y, int d);
    case (d)
      SIDE_N:  return (y != LAST) && rmap[y+1][x];
      SIDE_E:  return (x != LAST) && rmap[y][x+1];
      SIDE_S:  return (y != 0) && rmap[y-1][x];
      default: return (x != 0) && rmap[y][x-1];
    endcase
  endfunction

  task automatic put_wall(int x, int y, int d, logic v);
    case (d)
      SIDE_N:  if (y != LAST) hwall[y][x] = v;
      SIDE_E:  if (x != LAST) vwall[x][y] = v;
      SIDE_S:  if (y != 0) hwall[y-1][x] = v;
      default: if (x != 0) vwall[x-1][y] = v;
    endcase
  endtask

  task automatic maze_predict(input req_t r, output rsp_t p);
    int x;
    int y;
    logic [3:0] w;
    x = int'(r.x_pos);
    y = int'(r.y_pos);
    w = '0;
    case (r.req_type) inside
      REQ_ADD, REQ_SET: begin
        for (int d = 0; d < 4; d++) begin
          if (r.wall_mask[d]) put_wall(x, y, d, 1'b1);
          else if (r.req_type == REQ_SET) put_wall(x, y, d, 1'b0);
        end
      end
      REQ_MARK: rmap[y][x] = 1'b1;
      REQ_READ: begin
        for (int d = 0; d < 4; d++) w[d] = wall_at(x, y, d);
      end
      REQ_READ_KNWN: begin
        for (int d = 0; d < 4; d++)
          w[d] = wall_at(x, y, d) || !(rmap[y][x] || nbr_reached(x, y, d));
      end
      REQ_CLR_ALL: map_clear(1'b1);
      REQ_CLR_RCH: map_clear(1'b0);
      default: ;
    endcase
    p.walls_out = w;
    p.cell_reached = rmap[y][x];
  endtask

  task automatic send_req(input req_t r, input logic use_typed, input rsp_t typed);
    rsp_t p;
    int gap;
    in_ch.valid     <= 1'b1;
    in_ch.req_type  <= r.req_type;
    in_ch.x_pos     <= r.x_pos;
    in_ch.y_pos     <= r.y_pos;
    in_ch.wall_mask <= r.wall_mask;
    do @(posedge clk); while (!in_ch.ready);
    maze_predict(r, p);
    pending_rsp.push_back(use_typed ? typed : p);
    gap = tx_idle_on ? $urandom_range(0, 16) : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic req_t rand_req(req_t prev);
    req_t r;
    int sel;
    int d;
    sel = $urandom_range(0, 99);
    if (sel < 18) r.req_type = REQ_ADD;
    else if (sel < 30) r.req_type = REQ_SET;
    else if (sel < 48) r.req_type = REQ_MARK;
    else if (sel < 70) r.req_type = REQ_READ;
    else if (sel < 95) r.req_type = REQ_READ_KNWN;
    else if (sel < 97) r.req_type = REQ_CLR_RCH;
    else if (sel < 98) r.req_type = REQ_CLR_ALL;
    else r.req_type = REQ_NONE;
    r.wall_mask = 4'($urandom_range(0, 15));
    sel = $urandom_range(0, 9);
    if (sel < 4) begin
      r.x_pos = 5'($urandom_range(0, LAST));
      r.y_pos = 5'($urandom_range(0, LAST));
    end else if (sel < 6) begin
      r.x_pos = $urandom_range(0, 1) ? 5'(LAST) : 5'd0;
      r.y_pos = $urandom_range(0, 2) == 0 ? 5'($urandom_range(0, LAST))
              : ($urandom_range(0, 1) ? 5'(LAST) : 5'd0);
    end else begin
      // step to a neighbor of the last cell
      r.x_pos = prev.x_pos;
      r.y_pos = prev.y_pos;
      d = $urandom_range(0, 3);
      case (d)
        SIDE_N:  r.y_pos = (prev.y_pos == LAST) ? prev.y_pos - 5'd1 : prev.y_pos + 5'd1;
        SIDE_E:  r.x_pos = (prev.x_pos == LAST) ? prev.x_pos - 5'd1 : prev.x_pos + 5'd1;
        SIDE_S:  r.y_pos = (prev.y_pos == 0) ? prev.y_pos + 5'd1 : prev.y_pos - 5'd1;
        default: r.x_pos = (prev.x_pos == 0) ? prev.x_pos + 5'd1 : prev.x_pos - 5'd1;
      endcase
    end
    return r;
  endfunction

  // result beat checker
  always @(posedge clk) begin
    rsp_t e;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      rsp_cnt <= rsp_cnt + 1;
      if (pending_rsp.size() == 0) begin
        $error("result beat with no request pending: walls_out %h, cell_reached %b",
               out_ch.walls_out, out_ch.cell_reached);
        mismatch_cnt++;
      end else begin
        e = pending_rsp.pop_front();
        if (out_ch.walls_out !== e.walls_out) begin
          $error("walls_out: expected %h, got %h", e.walls_out, out_ch.walls_out);
          mismatch_cnt++;
        end
        if (out_ch.cell_reached !== e.cell_reached) begin
          $error("cell_reached: expected %b, got %b", e.cell_reached, out_ch.cell_reached);
          mismatch_cnt++;
        end
      end
    end
  end

  // result side ready
  initial begin
    int gap;
    int n;
    out_ch.ready <= 1'b0;
    n = 0;
    @(posedge rst_n);
    forever begin
      n++;
      if (n % 150 == 0) rx_idle_on = $urandom_range(0, 1);
      gap = rx_idle_on ? $urandom_range(0, 16) : 0;
      if (!rx_hold_done && rsp_cnt >= 300) begin
        rx_hold_done = 1'b1;
        gap = 300;
      end
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  initial begin
    #4000000;
    $display("Mismatches found");
    $finish;
  end

  initial begin
    req_t r;
    rsp_t none;
    r = '0;
    none = '0;
    rst_n           <= 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.req_type  <= REQ_READ;
    in_ch.x_pos     <= '0;
    in_ch.y_pos     <= '0;
    in_ch.wall_mask <= '0;
    map_clear(1'b1);
    vwall[0][0] = 1'b1;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < N_DIR; i++)
      send_req(dir_tab[i].req, dir_tab[i].chk, dir_tab[i].rsp);

    r = dir_tab[N_DIR-1].req;
    for (int i = 0; i < N_RANDOM; i++) begin
      if (i % 128 == 0) tx_idle_on = $urandom_range(0, 1);
      if (i == N_RANDOM / 2) begin
        in_ch.valid <= 1'b0;
        while (pending_rsp.size() != 0) @(posedge clk);
      end
      r = rand_req(r);
      send_req(r, 1'b0, none);
    end
    in_ch.valid <= 1'b0;

    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatch_cnt == 0 && pending_rsp.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
`default_nettype wire
